// ===== hw/rtl/ptp_pkg.sv =====
package ptp_pkg;

    // field and port widths
    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int WORLD_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared unit widths
    localparam int QUO_W  = 35;   // dividend and quotient
    localparam int DEN_W  = 17;   // twice the focal length
    localparam int PROD_W = 59;   // accumulator
    localparam int RND_W  = 43;   // product after the 1/65536 rounding
    localparam int CNT_W  = 6;

    // step counts per pass of the shared unit
    localparam logic [CNT_W-1:0] DIV_STEPS       = 6'd35;
    localparam logic [CNT_W-1:0] MUL_DEPTH_STEPS = 6'd24;
    localparam logic [CNT_W-1:0] MUL_POSE_STEPS  = 6'd16;

    // camera pose and tool offsets, 1/256 mm; rotation in Q16
    localparam logic [15:0]        POSE_K    = 16'd46341;
    localparam logic signed [44:0] CAM_TX_DX = 45'sd86641;  // translation x plus tool x
    localparam logic signed [44:0] CAM_TY    = 45'sd23629;
    localparam logic signed [24:0] CAM_TZ    = 25'sd210867;
    localparam logic signed [44:0] TOOL_DZ   = 45'sd52480;
    localparam logic signed [44:0] SAT_HI    = 45'sd8388607;
    localparam logic signed [44:0] SAT_LO    = -45'sd8388608;

    // register reset values
    localparam logic [15:0]        FOCAL_X_RST      = 16'd17091;
    localparam logic [15:0]        FOCAL_Y_RST      = 16'd17092;
    localparam logic [15:0]        CENTER_X_RST     = 16'd15241;
    localparam logic [15:0]        CENTER_Y_RST     = 16'd8602;
    localparam logic signed [23:0] PLANE_HEIGHT_RST = 24'sd39148;

    typedef logic signed [WORLD_W-1:0] world_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X        = 3'd0,
        REG_FOCAL_Y        = 3'd1,
        REG_CENTER_X       = 3'd2,
        REG_CENTER_Y       = 3'd3,
        REG_PLANE_HEIGHT   = 3'd4,
        REG_CONVEYOR_SPEED = 3'd5,
        REG_POINT_INTERVAL = 3'd6,
        REG_START_DELAY    = 3'd7
    } ptp_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIVX_LD,
        S_DIVX,
        S_DIVY_LD,
        S_DIVY,
        S_SUM,
        S_MX1_LD,
        S_MX1,
        S_MX2_LD,
        S_MX2,
        S_MY1_LD,
        S_MY1,
        S_MY2_LD,
        S_MY2,
        S_FIN,
        S_WRITE,
        S_CLOSE
    } ptp_state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD_DIV,
        OP_LOAD_MUL,
        OP_STEP_DIV,
        OP_STEP_MUL
    } ptp_op_t;

    typedef struct packed {
        ptp_op_t           op;
        logic [QUO_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
        logic [PROD_W-1:0] mcand;
        logic [QUO_W-1:0]  mplier;
    } ptp_cmd_t;

    // divide by 65536, rounded half away from zero, on a magnitude
    function automatic logic [RND_W-1:0] rnd16(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + (PROD_W+1)'(32768);
        return s[RND_W+15:16];
    endfunction

    // clamp to the signed 24-bit range
    function automatic world_t sat24(input logic signed [44:0] x);
        world_t r;
        if (x > SAT_HI)
            r = 24'sh7FFFFF;
        else if (x < SAT_LO)
            r = 24'sh800000;
        else
            r = x[WORLD_W-1:0];
        return r;
    endfunction

    // shift accumulation, clamped at all ones
    function automatic logic [39:0] sat_shift(input logic [39:0] a, input logic [31:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {9'b0, b};
        return s[40] ? '1 : s[39:0];
    endfunction

endpackage

// ===== hw/rtl/ptp_pix_if.sv =====
interface ptp_pix_if;
    import ptp_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
    logic             final_point;

    modport source (output valid, pixel_col, pixel_row, final_point, input ready);
    modport sink   (input valid, pixel_col, pixel_row, final_point, output ready);
endinterface

// ===== hw/rtl/ptp_pt_if.sv =====
interface ptp_pt_if;
    import ptp_pkg::*;

    logic   valid;
    logic   ready;
    world_t world_x;
    world_t world_y;
    world_t world_z;
    logic   closing_point;
    logic   run_end;

    modport source (output valid, world_x, world_y, world_z, closing_point, run_end,
                    input ready);
    modport sink   (input valid, world_x, world_y, world_z, closing_point, run_end,
                    output ready);
endinterface

// ===== hw/rtl/pixel_to_plane_with_conveyor_shift.sv =====
// The block takes one pixel at a time: a new pixel is accepted only once
// the last one's result word (and, for a run's final pixel, the closing
// word that follows it) has been loaded. The shared shift/add/subtract
// unit does the work in 70 divide steps and 80 multiply steps.
// Reset (rst_n low, asynchronous): registers to their defaults, run state
// cleared so the next pixel starts a run, no result pending.
module pixel_to_plane_with_conveyor_shift #(
    parameter int IMAGE_WIDTH = 1920
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ptp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptp_pkg::CFG_DATA_W-1:0] cfg_data,
    ptp_pix_if.sink                        pixel,
    ptp_pt_if.source                       point
);
    import ptp_pkg::*;

    localparam logic signed [17:0] WIDTH_X16 = 18'(IMAGE_WIDTH * 16);

    // configuration registers
    logic [15:0]        focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic signed [23:0] plane_height_reg;
    logic [15:0]        speed_reg, interval_reg, delay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg      <= FOCAL_X_RST;
            focal_y_reg      <= FOCAL_Y_RST;
            center_x_reg     <= CENTER_X_RST;
            center_y_reg     <= CENTER_Y_RST;
            plane_height_reg <= PLANE_HEIGHT_RST;
            speed_reg        <= '0;
            interval_reg     <= '0;
            delay_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (ptp_reg_t'(cfg_index))
                REG_FOCAL_X:        focal_x_reg      <= cfg_data[15:0];
                REG_FOCAL_Y:        focal_y_reg      <= cfg_data[15:0];
                REG_CENTER_X:       center_x_reg     <= cfg_data[15:0];
                REG_CENTER_Y:       center_y_reg     <= cfg_data[15:0];
                REG_PLANE_HEIGHT:   plane_height_reg <= cfg_data;
                REG_CONVEYOR_SPEED: speed_reg        <= cfg_data[15:0];
                REG_POINT_INTERVAL: interval_reg     <= cfg_data[15:0];
                REG_START_DELAY:    delay_reg        <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // values taken from configuration
    logic [15:0]        fx_eff, fy_eff;
    logic signed [24:0] depth;
    logic               depth_neg;
    logic [23:0]        depth_mag;
    logic signed [44:0] height_ext;

    assign fx_eff     = (focal_x_reg == '0) ? 16'd1 : focal_x_reg;
    assign fy_eff     = (focal_y_reg == '0) ? 16'd1 : focal_y_reg;
    assign depth      = CAM_TZ - {plane_height_reg[23], plane_height_reg};
    assign depth_neg  = depth[24];
    assign depth_mag  = depth_neg ? 24'(-depth) : depth[23:0];
    assign height_ext = {{21{plane_height_reg[23]}}, plane_height_reg};

    // offsets from the principal point, 1/16 pixel
    logic signed [17:0] du, dv;

    assign du = WIDTH_X16 - $signed({2'b0, pixel.pixel_col, 4'b0})
                - $signed({2'b0, center_x_reg});
    assign dv = $signed({2'b0, pixel.pixel_row, 4'b0}) - $signed({2'b0, center_y_reg});

    // sequencer
    ptp_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              step_last;
    logic              slot_free;
    logic              load_main, load_close;
    logic              in_ready;
    ptp_cmd_t          cmd;
    logic [QUO_W-1:0]  quot;
    logic [PROD_W-1:0] prod;

    // datapath registers
    logic               du_neg_reg, dv_neg_reg, fin_reg;
    logic [16:0]        du_mag_reg, dv_mag_reg;
    logic signed [35:0] nx_reg, diff_reg, sum_reg;
    logic [31:0]        step_prod_reg, delay_prod_reg;
    logic [RND_W-1:0]   pxm_reg;
    world_t             wx_reg, sy_reg;

    // run state
    world_t             first_x_reg, first_y_reg;
    logic [39:0]        running_shift_reg;
    logic               at_run_start_reg;

    // output word register
    logic               out_valid_reg;
    world_t             out_x_reg, out_y_reg, out_z_reg;
    logic               out_closing_reg, out_end_reg;

    logic [RND_W-1:0]   rnd_prod;
    logic signed [35:0] ny_now;
    logic [34:0]        diff_mag, sum_mag;
    logic               px_neg, py_neg;
    logic signed [44:0] pxs, pys;
    logic [39:0]        shift_now;
    world_t             wy_now, wy_close, wz_now;

    assign slot_free = !out_valid_reg || point.ready;
    assign rnd_prod  = rnd16(prod);
    assign ny_now    = dv_neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign diff_mag  = diff_reg[35] ? 35'(-diff_reg) : diff_reg[34:0];
    assign sum_mag   = sum_reg[35] ? 35'(-sum_reg) : sum_reg[34:0];

    // step count of the running pass
    always_comb
    begin
        unique case (state_reg)
            S_DIVX, S_DIVY: step_last = cnt_reg == DIV_STEPS - 6'd1;
            S_MX1, S_MY1:   step_last = cnt_reg == MUL_DEPTH_STEPS - 6'd1;
            S_MX2, S_MY2:   step_last = cnt_reg == MUL_POSE_STEPS - 6'd1;
            default:        step_last = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (pixel.valid) state_next = S_DIVX_LD;
            S_DIVX_LD: state_next = S_DIVX;
            S_DIVX:    if (step_last) state_next = S_DIVY_LD;
            S_DIVY_LD: state_next = S_DIVY;
            S_DIVY:    if (step_last) state_next = S_SUM;
            S_SUM:     state_next = S_MX1_LD;
            S_MX1_LD:  state_next = S_MX1;
            S_MX1:     if (step_last) state_next = S_MX2_LD;
            S_MX2_LD:  state_next = S_MX2;
            S_MX2:     if (step_last) state_next = S_MY1_LD;
            S_MY1_LD:  state_next = S_MY1;
            S_MY1:     if (step_last) state_next = S_MY2_LD;
            S_MY2_LD:  state_next = S_MY2;
            S_MY2:     if (step_last) state_next = S_FIN;
            S_FIN:     state_next = S_WRITE;
            S_WRITE:   if (slot_free) state_next = fin_reg ? S_CLOSE : S_IDLE;
            S_CLOSE:   if (slot_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: unit commands, handshake, word loads
    always_comb
    begin
        cmd        = '{op: OP_HOLD, dividend: '0, divisor: '0, mcand: '0, mplier: '0};
        cnt_next   = '0;
        in_ready   = 1'b0;
        load_main  = 1'b0;
        load_close = 1'b0;
        unique case (state_reg)
            S_IDLE:
                in_ready = 1'b1;
            S_DIVX_LD:
            begin
                cmd.op       = OP_LOAD_DIV;
                cmd.dividend = {1'b0, du_mag_reg, 17'b0} + {19'b0, fx_eff};
                cmd.divisor  = {fx_eff, 1'b0};
            end
            S_DIVY_LD:
            begin
                cmd.op       = OP_LOAD_DIV;
                cmd.dividend = {1'b0, dv_mag_reg, 17'b0} + {19'b0, fy_eff};
                cmd.divisor  = {fy_eff, 1'b0};
            end
            S_DIVX, S_DIVY:
            begin
                cmd.op   = OP_STEP_DIV;
                cnt_next = cnt_reg + 6'd1;
            end
            S_MX1_LD:
            begin
                cmd.op     = OP_LOAD_MUL;
                cmd.mcand  = {24'b0, diff_mag};
                cmd.mplier = {11'b0, depth_mag};
            end
            S_MY1_LD:
            begin
                cmd.op     = OP_LOAD_MUL;
                cmd.mcand  = {24'b0, sum_mag};
                cmd.mplier = {11'b0, depth_mag};
            end
            S_MX2_LD, S_MY2_LD:
            begin
                cmd.op     = OP_LOAD_MUL;
                cmd.mcand  = {16'b0, rnd_prod};
                cmd.mplier = {19'b0, POSE_K};
            end
            S_MX1, S_MX2, S_MY1, S_MY2:
            begin
                cmd.op   = OP_STEP_MUL;
                cnt_next = cnt_reg + 6'd1;
            end
            S_WRITE:
                load_main = slot_free;
            S_CLOSE:
                load_close = slot_free;
            default:
            begin
            end
        endcase
    end

    assign pixel.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    ptp_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .quot  (quot),
        .prod  (prod)
    );

    // back projection, sign and magnitude kept apart
    assign px_neg = diff_reg[35] ^ depth_neg;
    assign py_neg = sum_reg[35] ^ depth_neg;
    assign pxs    = px_neg ? -$signed({2'b0, pxm_reg}) : $signed({2'b0, pxm_reg});
    assign pys    = py_neg ? -$signed({2'b0, rnd_prod}) : $signed({2'b0, rnd_prod});

    always_ff @(posedge clk)
    begin
        if (pixel.valid && in_ready)
        begin
            du_neg_reg    <= du[17];
            du_mag_reg    <= du[17] ? 17'(-du) : du[16:0];
            dv_neg_reg    <= dv[17];
            dv_mag_reg    <= dv[17] ? 17'(-dv) : dv[16:0];
            fin_reg       <= pixel.final_point;
            step_prod_reg <= speed_reg * interval_reg;
        end
        if (state_reg == S_DIVY_LD)
            nx_reg <= du_neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        if (state_reg == S_SUM)
        begin
            diff_reg       <= nx_reg - ny_now;
            sum_reg        <= nx_reg + ny_now;
            delay_prod_reg <= speed_reg * delay_reg;
        end
        if (state_reg == S_MY1_LD)
            pxm_reg <= rnd_prod;
        if (state_reg == S_FIN)
        begin
            wx_reg <= sat24(pxs + CAM_TX_DX);
            sy_reg <= sat24(CAM_TY - pys);
        end
    end

    // conveyor shift and output values
    assign shift_now = at_run_start_reg ? {8'b0, delay_prod_reg} : running_shift_reg;
    assign wy_now    = sat24({{21{sy_reg[23]}}, sy_reg} + $signed({5'b0, shift_now}));
    assign wy_close  = sat24({{21{first_y_reg[23]}}, first_y_reg}
                             + $signed({5'b0, running_shift_reg}));
    assign wz_now    = sat24(height_ext + TOOL_DZ);

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg       <= '0;
            first_y_reg       <= '0;
            running_shift_reg <= '0;
            at_run_start_reg  <= 1'b1;
        end
        else if (load_main)
        begin
            if (at_run_start_reg)
            begin
                first_x_reg <= wx_reg;
                first_y_reg <= sy_reg;
            end
            running_shift_reg <= sat_shift(shift_now, step_prod_reg);
            at_run_start_reg  <= 1'b0;
        end
        else if (load_close)
        begin
            at_run_start_reg <= 1'b1;
        end
    end

    // output word: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_main || load_close)
            out_valid_reg <= 1'b1;
        else if (point.ready)
            out_valid_reg <= 1'b0;
    end

    // output word: payload
    always_ff @(posedge clk)
    begin
        if (load_main)
        begin
            out_x_reg       <= wx_reg;
            out_y_reg       <= wy_now;
            out_z_reg       <= wz_now;
            out_closing_reg <= 1'b0;
            out_end_reg     <= 1'b0;
        end
        else if (load_close)
        begin
            out_x_reg       <= first_x_reg;
            out_y_reg       <= wy_close;
            out_z_reg       <= wz_now;
            out_closing_reg <= 1'b1;
            out_end_reg     <= 1'b1;
        end
    end

    assign point.valid         = out_valid_reg;
    assign point.world_x       = out_x_reg;
    assign point.world_y       = out_y_reg;
    assign point.world_z       = out_z_reg;
    assign point.closing_point = out_closing_reg;
    assign point.run_end       = out_end_reg;

    // one pixel at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> !pixel.ready)
        else $error("pixel taken while busy");

    // the closing word is always the last of its run
    a_close_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.closing_point |-> point.run_end)
        else $error("closing word without run end");

    // a run restarts once its closing word is loaded
    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load_close |=> at_run_start_reg && state_reg == S_IDLE)
        else $error("run not restarted after closing word");

endmodule

// ===== hw/rtl/ptp_unit.sv =====
module ptp_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ptp_pkg::ptp_cmd_t         cmd,
    output logic [ptp_pkg::QUO_W-1:0]  quot,
    output logic [ptp_pkg::PROD_W-1:0] prod
);
    import ptp_pkg::*;

    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [QUO_W-1:0]  mplier_reg, mplier_next;
    logic [DEN_W-1:0]  dsr_reg, dsr_next;

    logic [DEN_W+1:0]  rem_sh;
    logic [DEN_W+1:0]  rem_sub;
    logic              fits;

    // restoring divide: one quotient bit a step
    assign rem_sh  = {acc_reg[DEN_W:0], mcand_reg[QUO_W-1]};
    assign fits    = rem_sh >= {2'b0, dsr_reg};
    assign rem_sub = rem_sh - {2'b0, dsr_reg};

    // next value of the shared datapath
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dsr_next    = dsr_reg;
        unique case (cmd.op)
            OP_HOLD:
            begin
            end
            OP_LOAD_DIV:
            begin
                acc_next    = '0;
                mcand_next  = {(PROD_W-QUO_W)'(0), cmd.dividend};
                mplier_next = '0;
                dsr_next    = cmd.divisor;
            end
            OP_LOAD_MUL:
            begin
                acc_next    = '0;
                mcand_next  = cmd.mcand;
                mplier_next = cmd.mplier;
            end
            OP_STEP_DIV:
            begin
                acc_next    = {(PROD_W-DEN_W-2)'(0), (fits ? rem_sub : rem_sh)};
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {mplier_reg[QUO_W-2:0], fits};
            end
            OP_STEP_MUL:
            begin
                acc_next    = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[QUO_W-1:1]};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dsr_reg    <= dsr_next;
    end

    assign quot = mplier_reg;
    assign prod = acc_reg;

    // a focal length of zero is replaced before it gets here
    a_dsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD_DIV |=> dsr_reg != '0)
        else $error("divisor loaded as zero");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_STEP_DIV |=> acc_reg < {(PROD_W-DEN_W)'(0), dsr_reg})
        else $error("remainder not below divisor");

    // accumulator must never wrap
    a_acc_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_STEP_MUL |=> acc_reg >= $past(acc_reg))
        else $error("product accumulator wrapped");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import ptp_pkg::*;

    localparam int     IMG_W       = 1920;
    localparam int     HALF_PERIOD = 2;
    localparam int     RUN_LIMIT   = 12_000_000;
    localparam int     TAIL_CYCLES = 200;
    localparam int     IDLE_PAUSE  = 4;
    localparam int     ERR_SHOWN   = 10;
    localparam int     PHASES      = 10;
    localparam int     PHASE_ITEMS = 100;
    localparam int     SAT_RUN_LEN = 270;

    // camera pose, tool offsets and limits in 1/256 mm, rotation in Q16
    localparam longint ROT_K_Q16  = 46341;
    localparam longint CAM_X      = 83569;
    localparam longint CAM_Y      = 23629;
    localparam longint CAM_Z      = 210867;
    localparam longint TOOL_X     = 3072;
    localparam longint TOOL_Z     = 52480;
    localparam longint Q16_ONE    = 65536;
    localparam longint WORLD_MAX  = 8388607;
    localparam longint WORLD_MIN  = -8388608;
    localparam longint SHIFT_CEIL = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        world_t wx;
        world_t wy;
        world_t wz;
        logic   closing;
        logic   ends_run;
    } plane_point_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptp_pix_if pix_bus ();
    ptp_pt_if  pt_bus ();

    pixel_to_plane_with_conveyor_shift #(.IMAGE_WIDTH(IMG_W)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix_bus),
        .point     (pt_bus)
    );

    // shadow of the register file
    logic [15:0]        fx_q, fy_q, cx_q, cy_q;
    logic [15:0]        speed_q, interval_q, delay_q;
    logic signed [23:0] height_q;

    // run state of the projection
    longint first_x, first_y, next_shift;
    bit     at_run_start;

    plane_point_t expected_points[$];
    int           fault_count;
    int           burst_left;
    bit           src_steady;
    bit           sink_stalls;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // hard stop
    initial
    begin
        #RUN_LIMIT;
        $display("pixel_to_plane_with_conveyor_shift verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // projection arithmetic
    // ---------------------------------------------------------------

    // division rounded half away from zero
    function automatic longint div_half_away(input longint n, input longint d);
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic longint clamp_world(input longint v);
        if (v > WORLD_MAX)
            return WORLD_MAX;
        if (v < WORLD_MIN)
            return WORLD_MIN;
        return v;
    endfunction

    // works out the path words that one accepted pixel gives
    task automatic project_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                                 input logic fin);
        longint       fx, fy, du, dv, nx, ny, depth;
        longint       px, py, wx, sy, wz, wy, shift, shift_step, sum;
        plane_point_t pt;
        fx = longint'(fx_q);
        fy = longint'(fy_q);
        // a zero focal length behaves as one
        if (fx == 0)
            fx = 1;
        if (fy == 0)
            fy = 1;
        // mirrored column, may go negative past the image width
        du = (longint'(IMG_W) - longint'(col)) * 16 - longint'(cx_q);
        dv = longint'(row) * 16 - longint'(cy_q);
        nx = div_half_away(du * Q16_ONE, fx);
        ny = div_half_away(dv * Q16_ONE, fy);
        depth = CAM_Z - longint'(height_q);
        px = div_half_away(div_half_away((nx - ny) * depth, Q16_ONE) * ROT_K_Q16, Q16_ONE);
        py = div_half_away(div_half_away((nx + ny) * depth, Q16_ONE) * ROT_K_Q16, Q16_ONE);
        wx = clamp_world(px + CAM_X + TOOL_X);
        sy = clamp_world(CAM_Y - py);
        wz = clamp_world(longint'(height_q) + TOOL_Z);
        shift_step = longint'(speed_q) * longint'(interval_q);

        if (at_run_start)
        begin
            shift = longint'(speed_q) * longint'(delay_q);
            first_x = wx;
            first_y = sy;
            at_run_start = 1'b0;
        end
        else
            shift = next_shift;

        wy          = clamp_world(sy + shift);
        pt.wx       = wx[WORLD_W-1:0];
        pt.wy       = wy[WORLD_W-1:0];
        pt.wz       = wz[WORLD_W-1:0];
        pt.closing  = 1'b0;
        pt.ends_run = 1'b0;
        expected_points = {expected_points, pt};

        // shift for the next point, held at the 40-bit ceiling
        sum = shift + shift_step;
        next_shift = (sum > SHIFT_CEIL) ? SHIFT_CEIL : sum;

        // final pixel: repeat the first point with the following shift
        if (fin)
        begin
            wy          = clamp_world(first_y + next_shift);
            pt.wx       = first_x[WORLD_W-1:0];
            pt.wy       = wy[WORLD_W-1:0];
            pt.wz       = wz[WORLD_W-1:0];
            pt.closing  = 1'b1;
            pt.ends_run = 1'b1;
            expected_points = {expected_points, pt};
            at_run_start = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= ERR_SHOWN)
            $display("%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : check_points
        plane_point_t want, got;
        if (rst_n && pt_bus.valid && pt_bus.ready)
        begin
            got.wx       = pt_bus.world_x;
            got.wy       = pt_bus.world_y;
            got.wz       = pt_bus.world_z;
            got.closing  = pt_bus.closing_point;
            got.ends_run = pt_bus.run_end;
            if (expected_points.size() == 0)
                report_fault($sformatf("unexpected word x=%h y=%h z=%h closing=%b end=%b",
                                       got.wx, got.wy, got.wz, got.closing, got.ends_run));
            else
            begin
                want = expected_points.pop_front();
                if (got.wx !== want.wx || got.wy !== want.wy || got.wz !== want.wz ||
                    got.closing !== want.closing || got.ends_run !== want.ends_run)
                    report_fault($sformatf(
                        "word mismatch x=%h/%h y=%h/%h z=%h/%h closing=%b/%b end=%b/%b (exp/act)",
                        want.wx, got.wx, want.wy, got.wy, want.wz, got.wz,
                        want.closing, got.closing, want.ends_run, got.ends_run));
            end
        end
    end

    // receiver: random stalls of mixed length, or always ready
    initial
    begin : ready_pattern
        int hold;
        hold = 0;
        pt_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!sink_stalls)
                pt_bus.ready <= 1'b1;
            else if (hold > 0)
            begin
                pt_bus.ready <= 1'b0;
                hold--;
            end
            else
            begin
                pt_bus.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    hold = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            end
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic cfg_write(input ptp_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_FOCAL_X:        fx_q       = data[15:0];
            REG_FOCAL_Y:        fy_q       = data[15:0];
            REG_CENTER_X:       cx_q       = data[15:0];
            REG_CENTER_Y:       cy_q       = data[15:0];
            REG_PLANE_HEIGHT:   height_q   = data;
            REG_CONVEYOR_SPEED: speed_q    = data[15:0];
            REG_POINT_INTERVAL: interval_q = data[15:0];
            REG_START_DELAY:    delay_q    = data[15:0];
            default: ;
        endcase
    endtask

    // one pixel word, held until taken; unless the source is steady, bursts end in a random gap, possibly none
    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic fin);
        int gap;
        @(negedge clk);
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_col   <= col;
        pix_bus.pixel_row   <= row;
        pix_bus.final_point <= fin;
        forever
        begin
            @(posedge clk);
            if (pix_bus.ready)
                break;
        end
        project_pixel(col, row, fin);
        if (!src_steady)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                case ($urandom_range(0, 3))
                    0:       gap = 0;
                    1:       gap = $urandom_range(1, 4);
                    2:       gap = $urandom_range(5, 40);
                    default: gap = $urandom_range(41, 200);
                endcase
                if (gap > 0)
                begin
                    @(negedge clk);
                    pix_bus.valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    endtask

    // stop sending, wait for every expected word, let the block fall idle
    task automatic settle_block();
        @(negedge clk);
        pix_bus.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    // a run of random pixels, the last one marked final
    task automatic random_run(input int len);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 3))
                0:       col = COL_W'($urandom);
                1:
                begin
                    case ($urandom_range(0, 3))
                        0:       col = '0;
                        1:       col = COL_W'(IMG_W - 1);
                        2:       col = COL_W'(IMG_W);
                        default: col = '1;
                    endcase
                end
                default: col = COL_W'($urandom_range(0, IMG_W - 1));
            endcase
            if ($urandom_range(0, 5) == 0)
                row = $urandom_range(0, 1) ? '1 : '0;
            else
                row = ROW_W'($urandom);
            send_pixel(col, row, i == len - 1);
        end
    endtask

    function automatic logic [15:0] pick_focal();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(8000, 30000));
        endcase
    endfunction

    function automatic logic [15:0] pick_center();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(4000, 32000));
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // settings after reset: image corners, edges of the width, single-point run
    task automatic test_default_setting();
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'hFFF, 12'hFFF, 1'b0);
        send_pixel(12'(IMG_W), 12'd0, 1'b0);
        send_pixel(12'(IMG_W - 1), 12'hFFF, 1'b1);
        send_pixel(12'd960, 12'd540, 1'b1);
        settle_block();
    endtask

    // zero and full-scale focal lengths, plane at both ends, full-scale shift
    task automatic test_extreme_setting();
        cfg_write(REG_FOCAL_X, 24'd0);
        cfg_write(REG_FOCAL_Y, 24'd0);
        cfg_write(REG_CENTER_X, 24'd0);
        cfg_write(REG_CENTER_Y, 24'd0);
        cfg_write(REG_PLANE_HEIGHT, 24'h7FFFFF);
        cfg_write(REG_CONVEYOR_SPEED, 24'hFFFF);
        cfg_write(REG_POINT_INTERVAL, 24'hFFFF);
        cfg_write(REG_START_DELAY, 24'hFFFF);
        send_pixel(12'd0, 12'hFFF, 1'b0);
        send_pixel(12'hFFF, 12'd0, 1'b1);
        settle_block();
        cfg_write(REG_FOCAL_X, 24'hFFFF);
        cfg_write(REG_FOCAL_Y, 24'hFFFF);
        cfg_write(REG_CENTER_X, 24'hFFFF);
        cfg_write(REG_CENTER_Y, 24'hFFFF);
        cfg_write(REG_PLANE_HEIGHT, 24'h800000);
        cfg_write(REG_CONVEYOR_SPEED, 24'd1);
        cfg_write(REG_POINT_INTERVAL, 24'd0);
        cfg_write(REG_START_DELAY, 24'd0);
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'hFFF, 12'hFFF, 1'b1);
        settle_block();
    endtask

    // settings changed between points of one run, then closing shift of a lone point
    task automatic test_midrun_change();
        cfg_write(REG_FOCAL_X, 24'(FOCAL_X_RST));
        cfg_write(REG_FOCAL_Y, 24'(FOCAL_Y_RST));
        cfg_write(REG_CENTER_X, 24'(CENTER_X_RST));
        cfg_write(REG_CENTER_Y, 24'(CENTER_Y_RST));
        cfg_write(REG_PLANE_HEIGHT, 24'(PLANE_HEIGHT_RST));
        cfg_write(REG_CONVEYOR_SPEED, 24'd100);
        cfg_write(REG_POINT_INTERVAL, 24'd7);
        cfg_write(REG_START_DELAY, 24'd20);
        send_pixel(12'd1000, 12'd500, 1'b0);
        settle_block();
        cfg_write(REG_CONVEYOR_SPEED, 24'd300);
        cfg_write(REG_POINT_INTERVAL, 24'd3);
        cfg_write(REG_PLANE_HEIGHT, 24'(-5000));
        send_pixel(12'd1200, 12'd600, 1'b0);
        settle_block();
        cfg_write(REG_CONVEYOR_SPEED, 24'd0);
        cfg_write(REG_PLANE_HEIGHT, 24'(PLANE_HEIGHT_RST));
        send_pixel(12'd900, 12'd400, 1'b1);
        settle_block();
        cfg_write(REG_CONVEYOR_SPEED, 24'd500);
        cfg_write(REG_POINT_INTERVAL, 24'd40);
        cfg_write(REG_START_DELAY, 24'd9);
        send_pixel(12'(IMG_W), 12'd2048, 1'b1);
        settle_block();
    endtask

    // long run at full-scale speed and interval so the shift hits its ceiling
    task automatic test_shift_saturation();
        cfg_write(REG_CONVEYOR_SPEED, 24'hFFFF);
        cfg_write(REG_POINT_INTERVAL, 24'hFFFF);
        cfg_write(REG_START_DELAY, 24'hFFFF);
        random_run(SAT_RUN_LEN);
        settle_block();
    endtask

    // random settings per phase, random runs, varied idling on both sides
    task automatic test_random_settings();
        int count, len, sel;
        logic [CFG_DATA_W-1:0] height;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            src_steady  = (phase % 4 == 1);
            sink_stalls = (phase % 4 != 2);
            sel = $urandom_range(0, 3);
            if (sel == 0)
                height = CFG_DATA_W'($urandom);
            else if (sel == 1)
                height = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            else
                height = CFG_DATA_W'(int'($urandom_range(0, 400000)) - 200000);
            cfg_write(REG_FOCAL_X, 24'(pick_focal()));
            cfg_write(REG_FOCAL_Y, 24'(pick_focal()));
            cfg_write(REG_CENTER_X, 24'(pick_center()));
            cfg_write(REG_CENTER_Y, 24'(pick_center()));
            cfg_write(REG_PLANE_HEIGHT, height);
            cfg_write(REG_CONVEYOR_SPEED, 24'(pick_rate()));
            cfg_write(REG_POINT_INTERVAL, 24'(pick_rate()));
            cfg_write(REG_START_DELAY, 24'(pick_rate()));
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                random_run(len);
                count += len;
            end
            settle_block();
        end
        src_steady  = 1'b0;
        sink_stalls = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_FOCAL_X;
        cfg_data            = '0;
        pix_bus.valid       = 1'b0;
        pix_bus.pixel_col   = '0;
        pix_bus.pixel_row   = '0;
        pix_bus.final_point = 1'b0;
        src_steady          = 1'b0;
        sink_stalls         = 1'b1;
        burst_left          = 0;
        fault_count         = 0;

        // register defaults and an empty run
        fx_q         = FOCAL_X_RST;
        fy_q         = FOCAL_Y_RST;
        cx_q         = CENTER_X_RST;
        cy_q         = CENTER_Y_RST;
        height_q     = PLANE_HEIGHT_RST;
        speed_q      = '0;
        interval_q   = '0;
        delay_q      = '0;
        first_x      = 0;
        first_y      = 0;
        next_shift   = 0;
        at_run_start = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_setting();
        test_extreme_setting();
        test_midrun_change();
        test_shift_saturation();
        test_random_settings();

        settle_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_points.size() == 0)
            $display("pixel_to_plane_with_conveyor_shift verification clean");
        else
            $display("pixel_to_plane_with_conveyor_shift verification failed");
        $finish;
    end

endmodule

// ===== pixel_to_plane_with_conveyor_shift.f =====
hw/rtl/ptp_pkg.sv
hw/rtl/ptp_pix_if.sv
hw/rtl/ptp_pt_if.sv
hw/rtl/ptp_unit.sv
hw/rtl/pixel_to_plane_with_conveyor_shift.sv
tb/tb_top.sv
